// ----- src/ckwdt_pkg.sv -----
package ckwdt_pkg;

    // Field widths fixed by the request and result formats.
    localparam int unsigned SOCK_W = 16;
    localparam int unsigned TICK_W = 32;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned CFG_W  = 32;

    // Default table size.
    localparam int unsigned SLOTS_DEFAULT = 4;

    // Stream packing.
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 168;

    // Configuration register map, selected by address bit 2.
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_STALE_LIMIT = 1'b0;
    localparam logic REG_PING_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] STALE_LIMIT_RESET = 32'd15001;
    localparam logic [CFG_W-1:0] PING_PERIOD_RESET = 32'd5000;

    localparam logic [TICK_W-1:0] AGE_UNKNOWN = {TICK_W{1'b1}};

    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_STOP      = 3'd1,
        REQ_RX        = 3'd2,
        REQ_CHECK     = 3'd3,
        REQ_PING_LINE = 3'd4,
        REQ_PONG_LINE = 3'd5,
        REQ_STATS     = 3'd6
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_STALE   = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [SOCK_W-1:0]  sock_id;
        logic               role_client;
        logic [TICK_W-1:0]  now_tick;
        logic               send_ok;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic               send_ping;
        logic               send_pong;
        logic [CNT_W-1:0]   pings_sent;
        logic [CNT_W-1:0]   pongs_sent;
        logic [CNT_W-1:0]   pongs_received;
        logic [CNT_W-1:0]   timeouts_seen;
        logic [TICK_W-1:0]  rx_age_ticks;
    } result_t;

endpackage

// ----- src/ckwdt_table.sv -----
module ckwdt_table
    import ckwdt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  request_t          req,
    input  logic [CFG_W-1:0]  stale_limit,
    input  logic [CFG_W-1:0]  ping_period,
    output result_t           res
);

    // Slot valid bits and running totals are control state; the slot
    // payload is only ever read behind a valid bit and needs no reset.
    logic [SLOTS-1:0]  valid_reg;
    logic [SOCK_W-1:0] socket_reg    [SLOTS];
    logic              client_reg    [SLOTS];
    logic [TICK_W-1:0] last_rx_reg   [SLOTS];
    logic [TICK_W-1:0] last_ping_reg [SLOTS];
    logic [CNT_W-1:0]  ping_cnt_reg  [SLOTS];
    logic [CNT_W-1:0]  pong_tx_reg   [SLOTS];
    logic [CNT_W-1:0]  pong_rx_reg   [SLOTS];
    logic [CNT_W-1:0]  timeout_reg   [SLOTS];

    // Sums over valid slots, kept up to date as counters move.
    logic [CNT_W-1:0] tot_ping_reg, tot_ping_next;
    logic [CNT_W-1:0] tot_pong_tx_reg, tot_pong_tx_next;
    logic [CNT_W-1:0] tot_pong_rx_reg, tot_pong_rx_next;
    logic [CNT_W-1:0] tot_timeout_reg, tot_timeout_next;

    logic [SLOTS-1:0]  hit_oh;
    logic [SLOTS-1:0]  free_oh;
    logic              hit_any;
    logic              free_any;
    logic              sock_zero;
    logic              rd_client;
    logic [TICK_W-1:0] rd_last_rx;
    logic [TICK_W-1:0] rd_last_ping;
    logic [CNT_W-1:0]  rd_ping;
    logic [CNT_W-1:0]  rd_pong_tx;
    logic [CNT_W-1:0]  rd_pong_rx;
    logic [CNT_W-1:0]  rd_timeout;
    logic [TICK_W-1:0] rx_age;
    logic [TICK_W-1:0] ping_age;
    logic              stale;
    logic              ping_due;

    // Per-request update strobes.
    logic do_start, do_stop, do_rx, do_ping, do_timeout, do_pong_tx, do_pong_rx;

    assign sock_zero = (req.sock_id == '0);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_oh[i] = valid_reg[i] && (socket_reg[i] == req.sock_id) && !sock_zero;
        end
    end

    // Lowest free slot, as a one-hot vector.
    always_comb
    begin
        logic found;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_oh[i] = !valid_reg[i] && !found;
            found      = found || !valid_reg[i];
        end
    end

    assign hit_any  = |hit_oh;
    assign free_any = |free_oh;

    // The matching slot is read through an AND-OR selector on the hit vector.
    always_comb
    begin
        rd_client    = 1'b0;
        rd_last_rx   = '0;
        rd_last_ping = '0;
        rd_ping      = '0;
        rd_pong_tx   = '0;
        rd_pong_rx   = '0;
        rd_timeout   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit_oh[i])
            begin
                rd_client    = rd_client    | client_reg[i];
                rd_last_rx   = rd_last_rx   | last_rx_reg[i];
                rd_last_ping = rd_last_ping | last_ping_reg[i];
                rd_ping      = rd_ping      | ping_cnt_reg[i];
                rd_pong_tx   = rd_pong_tx   | pong_tx_reg[i];
                rd_pong_rx   = rd_pong_rx   | pong_rx_reg[i];
                rd_timeout   = rd_timeout   | timeout_reg[i];
            end
        end
    end

    assign rx_age   = req.now_tick - rd_last_rx;
    assign ping_age = req.now_tick - rd_last_ping;
    assign stale    = (rx_age >= stale_limit);
    assign ping_due = rd_client && (ping_age >= ping_period) && req.send_ok;

    always_comb
    begin
        res        = '0;
        res.status = ST_OK;
        do_start   = 1'b0;
        do_stop    = 1'b0;
        do_rx      = 1'b0;
        do_ping    = 1'b0;
        do_timeout = 1'b0;
        do_pong_tx = 1'b0;
        do_pong_rx = 1'b0;
        case (req.req_type)
            REQ_START:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                else if (!hit_any)
                begin
                    if (free_any)
                    begin
                        do_start = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
            end
            REQ_STOP:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                do_stop = hit_any;
            end
            REQ_RX:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                do_rx = hit_any;
            end
            REQ_CHECK:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                else if (hit_any)
                begin
                    if (stale)
                    begin
                        do_timeout = 1'b1;
                        res.status = ST_STALE;
                    end
                    else if (ping_due)
                    begin
                        do_ping       = 1'b1;
                        res.send_ping = 1'b1;
                    end
                end
            end
            REQ_PING_LINE:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    res.send_pong = 1'b1;
                    do_pong_tx    = hit_any;
                end
            end
            REQ_PONG_LINE:
            begin
                if (sock_zero)
                begin
                    res.status = ST_INVALID;
                end
                do_pong_rx = hit_any;
            end
            REQ_STATS:
            begin
                res.rx_age_ticks = AGE_UNKNOWN;
                if (sock_zero)
                begin
                    res.pings_sent     = tot_ping_reg;
                    res.pongs_sent     = tot_pong_tx_reg;
                    res.pongs_received = tot_pong_rx_reg;
                    res.timeouts_seen  = tot_timeout_reg;
                end
                else if (hit_any)
                begin
                    res.pings_sent     = rd_ping;
                    res.pongs_sent     = rd_pong_tx;
                    res.pongs_received = rd_pong_rx;
                    res.timeouts_seen  = rd_timeout;
                    res.rx_age_ticks   = rx_age;
                end
            end
            default:
            begin
                // Request code seven is ignored.
            end
        endcase
    end

    // A stopped slot takes its counters out of the totals; a started slot
    // joins with cleared counters and so adds nothing.
    always_comb
    begin
        tot_ping_next    = tot_ping_reg;
        tot_pong_tx_next = tot_pong_tx_reg;
        tot_pong_rx_next = tot_pong_rx_reg;
        tot_timeout_next = tot_timeout_reg;
        if (do_stop)
        begin
            tot_ping_next    = tot_ping_reg - rd_ping;
            tot_pong_tx_next = tot_pong_tx_reg - rd_pong_tx;
            tot_pong_rx_next = tot_pong_rx_reg - rd_pong_rx;
            tot_timeout_next = tot_timeout_reg - rd_timeout;
        end
        if (do_ping)
        begin
            tot_ping_next = tot_ping_reg + CNT_W'(1);
        end
        if (do_pong_tx)
        begin
            tot_pong_tx_next = tot_pong_tx_reg + CNT_W'(1);
        end
        if (do_pong_rx)
        begin
            tot_pong_rx_next = tot_pong_rx_reg + CNT_W'(1);
        end
        if (do_timeout)
        begin
            tot_timeout_next = tot_timeout_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            tot_ping_reg    <= '0;
            tot_pong_tx_reg <= '0;
            tot_pong_rx_reg <= '0;
            tot_timeout_reg <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (do_start && free_oh[i])
                begin
                    valid_reg[i] <= 1'b1;
                end
                else if (do_stop && hit_oh[i])
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            tot_ping_reg    <= tot_ping_next;
            tot_pong_tx_reg <= tot_pong_tx_next;
            tot_pong_rx_reg <= tot_pong_rx_next;
            tot_timeout_reg <= tot_timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (do_start && free_oh[i])
                begin
                    socket_reg[i]    <= req.sock_id;
                    client_reg[i]    <= req.role_client;
                    last_rx_reg[i]   <= req.now_tick;
                    last_ping_reg[i] <= req.now_tick;
                    ping_cnt_reg[i]  <= '0;
                    pong_tx_reg[i]   <= '0;
                    pong_rx_reg[i]   <= '0;
                    timeout_reg[i]   <= '0;
                end
                if (hit_oh[i])
                begin
                    if (do_rx || do_pong_tx || do_pong_rx)
                    begin
                        last_rx_reg[i] <= req.now_tick;
                    end
                    if (do_ping)
                    begin
                        last_ping_reg[i] <= req.now_tick;
                        ping_cnt_reg[i]  <= ping_cnt_reg[i] + CNT_W'(1);
                    end
                    if (do_pong_tx)
                    begin
                        pong_tx_reg[i] <= pong_tx_reg[i] + CNT_W'(1);
                    end
                    if (do_pong_rx)
                    begin
                        pong_rx_reg[i] <= pong_rx_reg[i] + CNT_W'(1);
                    end
                    if (do_timeout)
                    begin
                        timeout_reg[i] <= timeout_reg[i] + CNT_W'(1);
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    ap_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_oh))
        else $error("Socket matches more than one tracked slot.");

    ap_start_lands: assert property (@(posedge clk) disable iff (!rst_n)
        en && do_start |=> $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("Start did not claim exactly one free slot.");

    ap_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && do_stop |=> (valid_reg & $past(hit_oh)) == '0)
        else $error("Stop left the slot tracked.");
`endif

endmodule

// ----- src/connection_keepalive_watchdog_table.sv -----
// Path: a transferred request is held in the input register, and its result is loaded
// into the result register once that register is empty or being taken, then offered.
// Throughput: one request per cycle while m_tready is high; the slot lookup, check
// and update of the slot table are done combinationally between the input and
// result registers. A held result stalls the request register and drops s_tready.
// Reset: all slots become free, the running totals clear, stale_limit_ticks
// returns to 15001 and ping_period_ticks to 5000. No clearing pass is needed.
module connection_keepalive_watchdog_table
    import ckwdt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, lowest bit up: sock_id[15:0], role_client, now_tick[31:0], send_ok,
    // then six zero bits.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[2:0].
    input  logic [S_TUSER_W-1:0]  s_tuser,

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, lowest bit up: status[1:0], send_ping, send_pong, pings_sent[31:0],
    // pongs_sent[31:0], pongs_received[31:0], timeouts_seen[31:0],
    // rx_age_ticks[31:0], then four zero bits.
    output logic [M_TDATA_W-1:0]  m_tdata,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]      pwdata,
    output logic [CFG_W-1:0]      prdata,
    output logic                  pready
);

    // Configuration registers. The user must write them only while the block is idle,
    // which the block itself does not enforce; the table uses them directly.
    logic [CFG_W-1:0] stale_limit_reg;
    logic [CFG_W-1:0] ping_period_reg;
    logic             cfg_write;

    // Input register holding the request under work, and the result register
    // that parts the master side from the table.
    logic     in_valid_reg;
    request_t in_req_reg;
    logic     out_valid_reg;
    result_t  out_res_reg;

    request_t s_req;
    result_t  table_res;
    logic     advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_STALE_LIMIT: prdata = stale_limit_reg;
            REG_PING_PERIOD: prdata = ping_period_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= STALE_LIMIT_RESET;
            ping_period_reg <= PING_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_STALE_LIMIT: stale_limit_reg <= pwdata;
                REG_PING_PERIOD: ping_period_reg <= pwdata;
            endcase
        end
    end

    // Unpack the slave-side transfer.
    assign s_req.req_type    = req_type_t'(s_tuser);
    assign s_req.sock_id     = s_tdata[15:0];
    assign s_req.role_client = s_tdata[16];
    assign s_req.now_tick    = s_tdata[48:17];
    assign s_req.send_ok     = s_tdata[49];

    // The held request moves into the result register whenever that register
    // is empty or its result is being taken in the same cycle. The table
    // commits its update on the same edge, so the next request sees it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg <= s_req;
        end
        if (advance)
        begin
            out_res_reg <= table_res;
        end
    end

    ckwdt_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .req         (in_req_reg),
        .stale_limit (stale_limit_reg),
        .ping_period (ping_period_reg),
        .res         (table_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.rx_age_ticks,
                       out_res_reg.timeouts_seen,
                       out_res_reg.pongs_received,
                       out_res_reg.pongs_sent,
                       out_res_reg.pings_sent,
                       out_res_reg.send_pong,
                       out_res_reg.send_ping,
                       out_res_reg.status};

`ifndef SYNTHESIS
    ap_ping_pong_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.send_ping && out_res_reg.send_pong))
        else $error("A result asks for both a ping and a pong.");

    ap_ping_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.send_ping |-> out_res_reg.status == ST_OK)
        else $error("A ping was sent with a non-ok status.");

    ap_held_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("A held request was lost or altered while stalled.");
`endif

endmodule

// ----- tb/tb_connection_keepalive_watchdog_table.sv -----
// Testbench for the keepalive watchdog table.
//
// Requests are queued by the stimulus process. A clocked driver offers them on the
// slave-side stream, and a clocked monitor checks each result transfer against
// the oldest entry in a queue of predicted answers. The predictor keeps its own
// copy of the slot table and of both registers. It works out the answer to each
// request at the clock edge where the request transfer is accepted.
module tb_connection_keepalive_watchdog_table;
    import ckwdt_pkg::*;

    localparam int unsigned TABLE_SLOTS = SLOTS_DEFAULT;
    // Request code that the block must ignore. It still answers with a zero result.
    localparam logic [2:0] REQ_UNDEFINED = 3'd7;
    localparam int unsigned IDLE_PCT = 10;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned HOLD_AT = 100;
    localparam int unsigned HOLD_LEN = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata, lowest bit up: sock_id[15:0], role_client, now_tick[31:0], send_ok,
    // then six zero bits.
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // s_tuser: req_type[2:0].
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata, lowest bit up: status[1:0], send_ping, send_pong, pings_sent[31:0],
    // pongs_sent[31:0], pongs_received[31:0], timeouts_seen[31:0],
    // rx_age_ticks[31:0], then four zero bits.
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]      pwdata = '0;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;

    connection_keepalive_watchdog_table #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The predictor's own view of the block: two registers and the slot table.
    logic [CFG_W-1:0]  cfg_stale_limit = STALE_LIMIT_RESET;
    logic [CFG_W-1:0]  cfg_ping_period = PING_PERIOD_RESET;
    logic              trk_valid [TABLE_SLOTS] = '{default: 1'b0};
    logic [SOCK_W-1:0] trk_sock [TABLE_SLOTS];
    logic              trk_client [TABLE_SLOTS];
    logic [TICK_W-1:0] trk_last_rx [TABLE_SLOTS];
    logic [TICK_W-1:0] trk_last_ping [TABLE_SLOTS];
    logic [CNT_W-1:0]  trk_pings [TABLE_SLOTS];
    logic [CNT_W-1:0]  trk_pongs_tx [TABLE_SLOTS];
    logic [CNT_W-1:0]  trk_pongs_rx [TABLE_SLOTS];
    logic [CNT_W-1:0]  trk_timeouts [TABLE_SLOTS];

    request_t request_queue [$];
    result_t  answer_q [$];
    request_t on_offer;

    // Stimulus state: the running tick, and the sockets that one phase of
    // traffic mostly talks about, so that starts, checks and stats hit
    // tracked slots most of the time.
    logic [TICK_W-1:0] tick_now;
    logic [SOCK_W-1:0] sock_pool [6];
    bit quiet = 1'b0;

    int unsigned error_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned stale_seen = 0;
    int unsigned pings_seen = 0;
    int unsigned full_seen = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit hold_done = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch after %0d results: %s is %h, expected %h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Works out the answer to one request and applies its effect to the table.
    function automatic result_t predict_answer(input request_t rq);
        result_t ans;
        int hit;
        int open_idx;
        logic [TICK_W-1:0] since_rx;
        logic [TICK_W-1:0] ping_gap;

        ans = '0;
        hit = -1;
        open_idx = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (rq.sock_id != '0 && trk_valid[i] && trk_sock[i] == rq.sock_id && hit < 0)
                hit = i;
            if (!trk_valid[i] && open_idx < 0)
                open_idx = i;
        end

        if (rq.sock_id == '0 && rq.req_type <= REQ_PONG_LINE)
            ans.status = ST_INVALID;
        else
        begin
            case (rq.req_type)
                REQ_START:
                    if (hit < 0)
                    begin
                        if (open_idx < 0)
                            ans.status = ST_FULL;
                        else
                        begin
                            trk_valid[open_idx] = 1'b1;
                            trk_sock[open_idx] = rq.sock_id;
                            trk_client[open_idx] = rq.role_client;
                            trk_last_rx[open_idx] = rq.now_tick;
                            trk_last_ping[open_idx] = rq.now_tick;
                            trk_pings[open_idx] = '0;
                            trk_pongs_tx[open_idx] = '0;
                            trk_pongs_rx[open_idx] = '0;
                            trk_timeouts[open_idx] = '0;
                        end
                    end
                REQ_STOP:
                    if (hit >= 0)
                        trk_valid[hit] = 1'b0;
                REQ_RX:
                    if (hit >= 0)
                        trk_last_rx[hit] = rq.now_tick;
                REQ_CHECK:
                    if (hit >= 0)
                    begin
                        since_rx = rq.now_tick - trk_last_rx[hit];
                        ping_gap = rq.now_tick - trk_last_ping[hit];
                        // Staleness wins over a due ping, whatever the role.
                        if (since_rx >= cfg_stale_limit)
                        begin
                            trk_timeouts[hit] = trk_timeouts[hit] + 1;
                            ans.status = ST_STALE;
                        end
                        else if (trk_client[hit] && ping_gap >= cfg_ping_period
                                 && rq.send_ok)
                        begin
                            trk_pings[hit] = trk_pings[hit] + 1;
                            trk_last_ping[hit] = rq.now_tick;
                            ans.send_ping = 1'b1;
                        end
                    end
                REQ_PING_LINE:
                begin
                    // A ping line is answered even for a socket that is not tracked.
                    ans.send_pong = 1'b1;
                    if (hit >= 0)
                    begin
                        trk_last_rx[hit] = rq.now_tick;
                        trk_pongs_tx[hit] = trk_pongs_tx[hit] + 1;
                    end
                end
                REQ_PONG_LINE:
                    if (hit >= 0)
                    begin
                        trk_last_rx[hit] = rq.now_tick;
                        trk_pongs_rx[hit] = trk_pongs_rx[hit] + 1;
                    end
                REQ_STATS:
                begin
                    ans.rx_age_ticks = AGE_UNKNOWN;
                    if (rq.sock_id == '0)
                    begin
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            if (trk_valid[i])
                            begin
                                ans.pings_sent = ans.pings_sent + trk_pings[i];
                                ans.pongs_sent = ans.pongs_sent + trk_pongs_tx[i];
                                ans.pongs_received = ans.pongs_received + trk_pongs_rx[i];
                                ans.timeouts_seen = ans.timeouts_seen + trk_timeouts[i];
                            end
                    end
                    else if (hit >= 0)
                    begin
                        ans.pings_sent = trk_pings[hit];
                        ans.pongs_sent = trk_pongs_tx[hit];
                        ans.pongs_received = trk_pongs_rx[hit];
                        ans.timeouts_seen = trk_timeouts[hit];
                        ans.rx_age_ticks = rq.now_tick - trk_last_rx[hit];
                    end
                end
                default:
                    ;
            endcase
        end
        return ans;
    endfunction

    task automatic push_req(input req_type_t kind, input logic [SOCK_W-1:0] sock,
                            input logic client, input logic [TICK_W-1:0] now,
                            input logic ok);
        request_t rq;

        rq.req_type = kind;
        rq.sock_id = sock;
        rq.role_client = client;
        rq.now_tick = now;
        rq.send_ok = ok;
        request_queue.push_back(rq);
    endtask

    // Waits until every queued request has been transferred and answered, then
    // lets the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        while (request_queue.size() != 0 || s_tvalid || answer_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // prdata is sampled half-way through the access cycle.
    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        value = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // One phase of random traffic under one register setting. The registers are
    // written only once the block has drained, and are then read back.
    task automatic run_phase(input logic [CFG_W-1:0] stale, input logic [CFG_W-1:0] ping,
                             input int count, input int unsigned max_step,
                             input logic [TICK_W-1:0] first_tick, input bit no_gaps);
        logic [CFG_W-1:0] readback;
        req_type_t kind;
        logic [SOCK_W-1:0] sock;
        int unsigned pick;

        wait_idle();
        apb_write({REG_STALE_LIMIT, 2'b00}, stale);
        cfg_stale_limit = stale;
        apb_write({REG_PING_PERIOD, 2'b00}, ping);
        cfg_ping_period = ping;
        apb_read({REG_STALE_LIMIT, 2'b00}, readback);
        compare_field("stale_limit_ticks read back", readback, stale);
        apb_read({REG_PING_PERIOD, 2'b00}, readback);
        compare_field("ping_period_ticks read back", readback, ping);
        settings_used++;
        quiet = no_gaps;
        for (int k = 0; k < 6; k++)
            sock_pool[k] = 16'($urandom_range(1, 65535));
        tick_now = first_tick;

        for (int n = 0; n < count; n++)
        begin
            // Checks dominate, with enough starts, stops and line events to keep
            // the table churning.
            pick = $urandom_range(0, 99);
            if (pick < 15)
                kind = REQ_START;
            else if (pick < 23)
                kind = REQ_STOP;
            else if (pick < 38)
                kind = REQ_RX;
            else if (pick < 63)
                kind = REQ_CHECK;
            else if (pick < 73)
                kind = REQ_PING_LINE;
            else if (pick < 83)
                kind = REQ_PONG_LINE;
            else if (pick < 97)
                kind = REQ_STATS;
            else
                kind = req_type_t'(REQ_UNDEFINED);

            // Mostly sockets from the pool; a few at random, and some zero.
            pick = $urandom_range(0, 99);
            if (pick < 4 || (kind == REQ_STATS && pick < 35))
                sock = '0;
            else if (pick < 10)
                sock = 16'($urandom_range(0, 65535));
            else
                sock = sock_pool[$urandom_range(0, 5)];

            // Time mostly creeps forward, sometimes leaps, and now and then is
            // anywhere at all.
            pick = $urandom_range(0, 99);
            if (pick < 3)
                tick_now = $urandom();
            else if (pick < 8)
                tick_now = tick_now + $urandom_range(0, 1000);
            else
                tick_now = tick_now + $urandom_range(0, max_step);

            push_req(kind, sock, 1'($urandom_range(0, 1)), tick_now,
                     $urandom_range(0, 3) != 0);
        end
    endtask

    // Driver. A new request is put on the bus only once the previous one has
    // been transferred, so tvalid is never dropped under a pending request.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                answer_q.push_back(predict_answer(on_offer));
                requests_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    on_offer = request_queue.pop_front();
                    s_tdata <= {{(S_TDATA_W - 50){1'b0}}, on_offer.send_ok, on_offer.now_tick,
                                on_offer.role_client, on_offer.sock_id};
                    s_tuser <= on_offer.req_type;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure. Once, early in the first random phase, the
    // receiver holds off for a long stretch so that the pipeline fills and the
    // block has to stall its request input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: unpacks each result transfer and compares it with the oldest
    // predicted answer, field by field.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tdata[1:0]);
            got.send_ping = m_tdata[2];
            got.send_pong = m_tdata[3];
            got.pings_sent = m_tdata[35:4];
            got.pongs_sent = m_tdata[67:36];
            got.pongs_received = m_tdata[99:68];
            got.timeouts_seen = m_tdata[131:100];
            got.rx_age_ticks = m_tdata[163:132];
            results_seen <= results_seen + 1;
            if (answer_q.size() == 0)
                report_mismatch("result with no request outstanding", m_tdata[31:0], '0);
            else
            begin
                want = answer_q.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("send_ping", 32'(got.send_ping), 32'(want.send_ping));
                compare_field("send_pong", 32'(got.send_pong), 32'(want.send_pong));
                compare_field("pings_sent", got.pings_sent, want.pings_sent);
                compare_field("pongs_sent", got.pongs_sent, want.pongs_sent);
                compare_field("pongs_received", got.pongs_received, want.pongs_received);
                compare_field("timeouts_seen", got.timeouts_seen, want.timeouts_seen);
                compare_field("rx_age_ticks", got.rx_age_ticks, want.rx_age_ticks);
                compare_field("tdata padding", 32'(m_tdata[M_TDATA_W-1:164]), '0);
                if (want.status == ST_STALE)
                    stale_seen++;
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.send_ping)
                    pings_seen++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, answer_q.size());
            $display("tb_connection_keepalive_watchdog_table: errors");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] readback;
        logic [TICK_W-1:0] t;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Both registers must come out of reset at their documented values.
        apb_read({REG_STALE_LIMIT, 2'b00}, readback);
        compare_field("stale_limit_ticks after reset", readback, STALE_LIMIT_RESET);
        apb_read({REG_PING_PERIOD, 2'b00}, readback);
        compare_field("ping_period_ticks after reset", readback, PING_PERIOD_RESET);

        // Directed opening under the reset register values. The base tick is
        // placed just below the wrap point, so that the tick differences wrap.
        t = 32'hFFFF_F000;
        push_req(REQ_STATS, '0, 1'b0, t, 1'b0);
        // Socket zero is refused by every defined request type except stats.
        for (int k = REQ_START; k <= REQ_PONG_LINE; k++)
            push_req(req_type_t'(k), '0, 1'b1, t, 1'b1);
        // Sockets that are not tracked.
        push_req(REQ_STATS, 16'h1234, 1'b0, t, 1'b0);
        push_req(REQ_CHECK, 16'h5555, 1'b1, t, 1'b1);
        push_req(REQ_PONG_LINE, 16'h5555, 1'b0, t, 1'b0);
        push_req(REQ_PING_LINE, 16'h5555, 1'b0, t, 1'b0);
        // Fill the table, overflow it, then restart a socket that is already tracked.
        push_req(REQ_START, 16'hFFFF, 1'b1, t, 1'b0);
        push_req(REQ_START, 16'h0001, 1'b0, t, 1'b0);
        push_req(REQ_START, 16'h8000, 1'b1, t, 1'b0);
        push_req(REQ_START, 16'h0002, 1'b0, t, 1'b0);
        push_req(REQ_START, 16'h0003, 1'b1, t, 1'b1);
        push_req(REQ_START, 16'hFFFF, 1'b0, t + 32'd7, 1'b1);
        // A due ping that cannot be sent, then the same ping going out.
        push_req(REQ_CHECK, 16'hFFFF, 1'b0, t + 32'd5000, 1'b0);
        push_req(REQ_CHECK, 16'hFFFF, 1'b0, t + 32'd5000, 1'b1);
        // Stale exactly at the limit for a server; one tick short of it, a
        // client gets its ping instead.
        push_req(REQ_CHECK, 16'h0001, 1'b1, t + 32'd15001, 1'b1);
        push_req(REQ_CHECK, 16'h8000, 1'b0, t + 32'd15000, 1'b1);
        push_req(REQ_PING_LINE, 16'h0001, 1'b0, t + 32'd15002, 1'b0);
        push_req(REQ_PONG_LINE, 16'h8000, 1'b1, t + 32'd15003, 1'b0);
        push_req(REQ_RX, 16'h0002, 1'b0, t + 32'd15004, 1'b1);
        push_req(REQ_STATS, 16'hFFFF, 1'b0, t + 32'd16000, 1'b0);
        push_req(REQ_STATS, '0, 1'b1, t + 32'd16000, 1'b1);
        push_req(req_type_t'(REQ_UNDEFINED), 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // A freed slot is reused by the next start.
        push_req(REQ_STOP, 16'h0002, 1'b0, 32'h0000_0000, 1'b0);
        push_req(REQ_START, 16'h0003, 1'b1, 32'h0000_0000, 1'b0);

        // Random phases, from short timers that trip often to the register extremes.
        // The first phase takes the long receiver hold-off. Every phase boundary
        // makes the sender wait until all outstanding answers have arrived.
        run_phase(32'd200, 32'd50, 180, 20, $urandom(), 1'b0);
        run_phase(32'd0, 32'd0, 120, 10, 32'h0000_0000, 1'b0);
        run_phase(32'd1, 32'hFFFF_FFFF, 120, 2, $urandom(), 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd1, 150, 10, 32'hFFFF_FFFF, 1'b0);
        run_phase(32'd500, 32'd120, 200, 30, 32'hFFFF_FF00, 1'b1);
        run_phase($urandom_range(50, 2000), $urandom_range(10, 500), 200, 40, $urandom(),
                  1'b0);

        wait_idle();
        $display("run covered %0d requests under %0d register settings",
                 requests_sent, settings_used);
        $display("answers included %0d stale, %0d ping and %0d table-full outcomes",
                 stale_seen, pings_seen, full_seen);
        if (error_count == 0)
            $display("tb_connection_keepalive_watchdog_table: clean");
        else
            $display("tb_connection_keepalive_watchdog_table: errors");
        $finish;
    end

endmodule
